// File: rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants for the RV32I executor: beat structs, item
// kinds, status and console event codes, opcodes and memory geometry.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int NUM_REGS  = 32;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = ADDR_W - 2;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int REG_AW    = $clog2(NUM_REGS);

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_EXEC    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_PRINT_INT  = 3'd1;
    localparam logic [2:0] EV_PRINT_STR  = 3'd2;
    localparam logic [2:0] EV_READ_INT   = 3'd3;
    localparam logic [2:0] EV_PRINT_CHAR = 3'd4;
    localparam logic [2:0] EV_EXIT       = 3'd5;
    localparam logic [2:0] EV_UNSUP      = 3'd6;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    localparam logic [31:0] EC_PRINT_INT  = 32'd1;
    localparam logic [31:0] EC_PRINT_STR  = 32'd4;
    localparam logic [31:0] EC_READ_INT   = 32'd5;
    localparam logic [31:0] EC_EXIT       = 32'd10;
    localparam logic [31:0] EC_PRINT_CHAR = 32'd11;
    localparam logic [31:0] EC_EXIT_CODE  = 32'd93;

    localparam logic [REG_AW-1:0] REG_A0 = REG_AW'(10);
    localparam logic [REG_AW-1:0] REG_A7 = REG_AW'(17);

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        mem_address;
        logic [31:0]        write_word;
        logic signed [31:0] console_input;
    } in_t;

    typedef struct packed {
        logic [31:0] read_word;
        logic [31:0] pc_now;
        logic [31:0] instr_word;
        logic [1:0]  status;
        logic [2:0]  console_event;
        logic [31:0] console_arg;
        logic        halted_now;
    } out_t;

    function automatic logic fits(input logic [31:0] addr, input logic [2:0] n);
        return ({1'b0, addr} + 33'(n)) <= 33'(MEM_BYTES);
    endfunction

endpackage

// File: rtl/rvx_ram.sv
// ----------------------------------------------------------------------------
// rvx_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/rv32i_instruction_executor.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_executor
// RV32I core with private byte memory; one beat in, one result beat out.
// ----------------------------------------------------------------------------
// After reset the core sweeps its memory to zero, one 32-bit row per cycle
// (16384 rows), and takes no beat until done. Memory is four byte-wide
// banks so any aligned or misaligned access of up to four bytes is one RAM
// access. A memory write, restart or refused execute ends in the idle state,
// a memory read waits on the RAM, an instruction runs fetch, register read
// and execute, and a load adds write-back; the read ports set those steps.
// A result register lets the next beat enter while a result waits.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rvx_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rvx_pkg::out_t out_data
);
    import rvx_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_DECODE = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_LOAD   = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [31:0]         pc_reg, pc_next;
    logic                halt_reg, halt_next;
    in_t                 item_reg, item_next;
    logic [31:0]         instr_reg, instr_next;
    logic [ADDR_W-1:0]   maddr_reg, maddr_sel;
    logic [REG_AW-1:0]   rs1_reg, rs2_reg, rs1_sel, rs2_sel;
    logic [NUM_REGS-1:0] rvalid_reg, rvalid_next;
    logic [ROW_W-1:0]    clr_reg, clr_next;
    out_t                out_reg, out_next, res_reg, res_next, res;
    logic                out_valid_reg, out_valid_next;
    logic                fin, out_free;

    logic              wr_en, wr_clear;
    logic [ADDR_W-1:0] wr_base;
    logic [31:0]       wr_word;
    logic [2:0]        wr_n;
    logic [63:0]       wdbl, rdbl;
    logic [31:0]       mem_word;
    logic [7:0]        bank_rdata [4];

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata, rf_rd1, rf_rd2;

    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j, pc4;
    logic [31:0] ex_next, ex_wb_val, ex_arg, eff_addr, ld_val;
    logic [REG_AW-1:0] ex_wb_addr;
    logic        ex_wb_en, ex_halt, ex_store, ex_load, ex_bad, ex_range, take;
    logic [1:0]  ex_status;
    logic [2:0]  ex_ev, ex_n;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign op    = instr_reg[6:0];
    assign rd    = instr_reg[11:7];
    assign f3    = instr_reg[14:12];
    assign f7    = instr_reg[31:25];
    assign imm_i = {{20{instr_reg[31]}}, instr_reg[31:20]};
    assign imm_s = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
    assign imm_b = {{20{instr_reg[31]}}, instr_reg[7], instr_reg[30:25],
                    instr_reg[11:8], 1'b0};
    assign imm_u = {instr_reg[31:12], 12'd0};
    assign imm_j = {{12{instr_reg[31]}}, instr_reg[19:12], instr_reg[20],
                    instr_reg[30:21], 1'b0};
    assign pc4   = pc_reg + 32'd4;
    assign a     = rvalid_reg[rs1_reg] ? rf_rd1 : 32'd0;
    assign b     = rvalid_reg[rs2_reg] ? rf_rd2 : 32'd0;

    // byte banks
    assign wdbl = {wr_word, wr_word} << {wr_base[1:0], 3'b000};
    assign rdbl = {bank_rdata[3], bank_rdata[2], bank_rdata[1], bank_rdata[0],
                   bank_rdata[3], bank_rdata[2], bank_rdata[1], bank_rdata[0]}
                  >> {maddr_reg[1:0], 3'b000};
    assign mem_word = rdbl[31:0];

    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [1:0]       lane;
        logic             we;
        logic [ROW_W-1:0] waddr, raddr;
        logic [7:0]       wdata;

        assign lane  = 2'(2'(j) - wr_base[1:0]);
        assign we    = wr_clear || (wr_en && ({1'b0, lane} < wr_n));
        assign waddr = wr_clear ? clr_reg
                     : wr_base[ADDR_W-1:2] + ROW_W'(2'(j) < wr_base[1:0]);
        assign wdata = wr_clear ? 8'd0 : wdbl[32 + 8*j +: 8];
        assign raddr = maddr_sel[ADDR_W-1:2] + ROW_W'(2'(j) < maddr_sel[1:0]);

        rvx_ram #(.WIDTH(8), .DEPTH(MEM_ROWS)) u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr),
            .rdata (bank_rdata[j])
        );
    end

    // register file, one copy per read port
    rvx_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf1 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rs1_sel),
        .rdata (rf_rd1)
    );

    rvx_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf2 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rs2_sel),
        .rdata (rf_rd2)
    );

    always_comb
    begin
        if (state_reg == S_DECODE)
        begin
            rs1_sel = (mem_word == ECALL_WORD) ? REG_A7 : mem_word[19:15];
            rs2_sel = (mem_word == ECALL_WORD) ? REG_A0 : mem_word[24:20];
        end
        else
        begin
            rs1_sel = rs1_reg;
            rs2_sel = rs2_reg;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:
                maddr_sel = (in_data.kind == KIND_EXEC) ? pc_reg[ADDR_W-1:0]
                          : ADDR_W'(in_data.mem_address);
            S_EXEC:  maddr_sel = eff_addr[ADDR_W-1:0];
            default: maddr_sel = maddr_reg;
        endcase
    end

    // execute
    always_comb
    begin
        ex_next    = pc4;
        ex_wb_en   = 1'b0;
        ex_wb_addr = rd;
        ex_wb_val  = 32'd0;
        ex_halt    = 1'b0;
        ex_store   = 1'b0;
        ex_load    = 1'b0;
        ex_bad     = 1'b0;
        ex_range   = 1'b0;
        ex_ev      = EV_NONE;
        ex_arg     = 32'd0;
        eff_addr   = a + imm_i;
        ex_n       = 3'd4;
        take       = 1'b0;
        case (op)
            OP_LOAD:
            begin
                ex_n = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)
                    ex_bad = 1'b1;
                else if (!fits(eff_addr, ex_n))
                    ex_range = 1'b1;
                else
                    ex_load = 1'b1;
            end
            OP_IMM:
            begin
                ex_wb_en = 1'b1;
                case (f3)
                    3'd0: ex_wb_val = a + imm_i;
                    3'd2: ex_wb_val = 32'($signed(a) < $signed(imm_i));
                    3'd3: ex_wb_val = 32'(a < imm_i);
                    3'd4: ex_wb_val = a ^ imm_i;
                    3'd6: ex_wb_val = a | imm_i;
                    3'd7: ex_wb_val = a & imm_i;
                    3'd1:
                    begin
                        ex_bad    = (f7 != 7'd0);
                        ex_wb_val = a << instr_reg[24:20];
                    end
                    default:
                    begin
                        if (f7 == 7'd0)
                            ex_wb_val = a >> instr_reg[24:20];
                        else if (f7 == F7_ALT)
                            ex_wb_val = 32'($signed(a) >>> instr_reg[24:20]);
                        else
                            ex_bad = 1'b1;
                    end
                endcase
            end
            OP_AUIPC:
            begin
                ex_wb_en  = 1'b1;
                ex_wb_val = pc_reg + imm_u;
            end
            OP_STORE:
            begin
                eff_addr = a + imm_s;
                ex_n     = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
                if (f3 > 3'd2)
                    ex_bad = 1'b1;
                else if (!fits(eff_addr, ex_n))
                    ex_range = 1'b1;
                else
                    ex_store = 1'b1;
            end
            OP_REG:
            begin
                ex_wb_en = 1'b1;
                if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))
                    ex_wb_val = (f3 == 3'd0) ? a - b : 32'($signed(a) >>> b[4:0]);
                else if (f7 != 7'd0)
                    ex_bad = 1'b1;
                else
                begin
                    case (f3)
                        3'd0: ex_wb_val = a + b;
                        3'd1: ex_wb_val = a << b[4:0];
                        3'd2: ex_wb_val = 32'($signed(a) < $signed(b));
                        3'd3: ex_wb_val = 32'(a < b);
                        3'd4: ex_wb_val = a ^ b;
                        3'd5: ex_wb_val = a >> b[4:0];
                        3'd6: ex_wb_val = a | b;
                        default: ex_wb_val = a & b;
                    endcase
                end
            end
            OP_LUI:
            begin
                ex_wb_en  = 1'b1;
                ex_wb_val = imm_u;
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = $signed(a) < $signed(b);
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = a < b;
                    3'd7: take = a >= b;
                    default: ex_bad = 1'b1;
                endcase
                if (take)
                    ex_next = pc_reg + imm_b;
            end
            OP_JALR:
            begin
                ex_bad    = (f3 != 3'd0);
                ex_next   = (a + imm_i) & ~32'd1;
                ex_wb_en  = 1'b1;
                ex_wb_val = pc4;
            end
            OP_JAL:
            begin
                ex_next   = pc_reg + imm_j;
                ex_wb_en  = 1'b1;
                ex_wb_val = pc4;
            end
            OP_SYSTEM:
            begin
                if (instr_reg != ECALL_WORD)
                    ex_bad = 1'b1;
                else
                begin
                    case (a)
                        EC_PRINT_INT:
                        begin
                            ex_ev  = EV_PRINT_INT;
                            ex_arg = b;
                        end
                        EC_PRINT_STR:
                        begin
                            ex_ev  = EV_PRINT_STR;
                            ex_arg = b;
                        end
                        EC_READ_INT:
                        begin
                            ex_ev      = EV_READ_INT;
                            ex_arg     = item_reg.console_input;
                            ex_wb_en   = 1'b1;
                            ex_wb_addr = REG_A0;
                            ex_wb_val  = item_reg.console_input;
                        end
                        EC_PRINT_CHAR:
                        begin
                            ex_ev  = EV_PRINT_CHAR;
                            ex_arg = {24'd0, b[7:0]};
                        end
                        EC_EXIT, EC_EXIT_CODE:
                        begin
                            ex_ev   = EV_EXIT;
                            ex_halt = 1'b1;
                        end
                        default:
                        begin
                            ex_ev   = EV_UNSUP;
                            ex_halt = 1'b1;
                        end
                    endcase
                end
            end
            default: ex_bad = 1'b1;
        endcase
        ex_status = ST_OK;
        if (ex_bad || ex_range)
        begin
            ex_status = ex_bad ? ST_INVALID : ST_RANGE;
            ex_halt   = 1'b1;
            ex_next   = pc_reg;
            ex_wb_en  = 1'b0;
            ex_store  = 1'b0;
            ex_load   = 1'b0;
            ex_ev     = EV_NONE;
            ex_arg    = 32'd0;
        end
        if (ex_wb_addr == '0)
            ex_wb_en = 1'b0;
    end

    always_comb
    begin
        case (f3)
            3'd0:    ld_val = {{24{mem_word[7]}}, mem_word[7:0]};
            3'd1:    ld_val = {{16{mem_word[15]}}, mem_word[15:0]};
            3'd4:    ld_val = {24'd0, mem_word[7:0]};
            3'd5:    ld_val = {16'd0, mem_word[15:0]};
            default: ld_val = mem_word;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        item_next      = item_reg;
        instr_next     = instr_reg;
        rvalid_next    = rvalid_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res            = '0;
        fin            = 1'b0;
        wr_en          = 1'b0;
        wr_clear       = 1'b0;
        wr_base        = maddr_sel;
        wr_word        = 32'd0;
        wr_n           = 3'd4;
        rf_we          = 1'b0;
        rf_waddr       = ex_wb_addr;
        rf_wdata       = ex_wb_val;
        case (state_reg)
            S_CLEAR:
            begin
                wr_clear = 1'b1;
                clr_next = clr_reg + ROW_W'(1);
                if (clr_reg == ROW_W'(MEM_ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    case (in_data.kind)
                        KIND_WRITE:
                        begin
                            fin = 1'b1;
                            if (fits(32'(in_data.mem_address), 3'd4))
                            begin
                                wr_en   = 1'b1;
                                wr_word = in_data.write_word;
                            end
                            else
                                res.status = ST_RANGE;
                        end
                        KIND_READ:
                        begin
                            if (fits(32'(in_data.mem_address), 3'd4))
                                state_next = S_RDWAIT;
                            else
                            begin
                                res.status = ST_RANGE;
                                fin        = 1'b1;
                            end
                        end
                        KIND_EXEC:
                        begin
                            if (halt_reg)
                            begin
                                res.status = ST_HALTED;
                                fin        = 1'b1;
                            end
                            else if (!fits(pc_reg, 3'd4))
                            begin
                                res.status = ST_RANGE;
                                halt_next  = 1'b1;
                                fin        = 1'b1;
                            end
                            else
                                state_next = S_DECODE;
                        end
                        default:
                        begin
                            pc_next     = 32'd0;
                            halt_next   = 1'b0;
                            rvalid_next = '0;
                            fin         = 1'b1;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res.read_word = mem_word;
                fin           = 1'b1;
            end
            S_DECODE:
            begin
                instr_next = mem_word;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (ex_load)
                    state_next = S_LOAD;
                else
                begin
                    fin               = 1'b1;
                    res.instr_word    = instr_reg;
                    res.status        = ex_status;
                    res.console_event = ex_ev;
                    res.console_arg   = ex_arg;
                    pc_next           = ex_next;
                    halt_next         = halt_reg || ex_halt;
                    wr_en             = ex_store;
                    wr_base           = eff_addr[ADDR_W-1:0];
                    wr_word           = b;
                    wr_n              = ex_n;
                    rf_we             = ex_wb_en;
                    if (ex_wb_en)
                        rvalid_next[ex_wb_addr] = 1'b1;
                end
            end
            S_LOAD:
            begin
                fin            = 1'b1;
                res.instr_word = instr_reg;
                pc_next        = pc4;
                rf_waddr       = rd;
                rf_wdata       = ld_val;
                rf_we          = (rd != 5'd0);
                if (rd != 5'd0)
                    rvalid_next[rd] = 1'b1;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        res.pc_now     = pc_next;
        res.halted_now = halt_next;
        if (fin)
        begin
            if (out_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = res;
                state_next = S_RESP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pc_reg        <= 32'd0;
            halt_reg      <= 1'b0;
            rvalid_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            rvalid_reg    <= rvalid_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        instr_reg <= instr_next;
        maddr_reg <= maddr_sel;
        rs1_reg   <= rs1_sel;
        rs2_reg   <= rs2_sel;
        out_reg   <= out_next;
        res_reg   <= res_next;
    end

endmodule

// File: rtl/rvx_checker.sv
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks for the RV32I executor, bound to the top level.
// ----------------------------------------------------------------------------
module rvx_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input rvx_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input rvx_pkg::out_t out_data
);
    import rvx_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_INVALID || out_data.status == ST_HALTED)
        |-> out_data.halted_now)
        else $error("fault or halted status without halt");

    a_event_ecall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.console_event != EV_NONE
        |-> out_data.status == ST_OK && out_data.instr_word == ECALL_WORD)
        else $error("console event without ecall");

    a_exit_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.console_event == EV_EXIT
                      || out_data.console_event == EV_UNSUP)
        |-> out_data.halted_now)
        else $error("exit event left core running");

endmodule

bind rv32i_instruction_executor rvx_checker u_rvx_checker (.*);
